### design/glpt_pkg.sv
// glpt_pkg: shared types, register indexes and constant tables for the
// gamma / logarithm pixel transform; no dependencies
`timescale 1ns / 1ps

package glpt_pkg;

  localparam int FRAC_BITS = 20;
  localparam int MANT_BITS = 30;
  localparam int EXP_STEPS = 20;
  localparam int C_W       = 24;
  localparam int G_W       = 20;
  localparam int TAB_W     = 23;
  localparam int E_W       = 27;
  localparam int PIX_W     = 8;
  localparam int ADDR_W    = 2;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  // register indexes of the configuration port
  typedef enum logic [ADDR_W-1:0] {
    REG_MODE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_GAMMA = 2'd2
  } reg_idx_t;

  typedef logic [TAB_W-1:0] tab_t [256];
  typedef logic [31:0] root_t [EXP_STEPS+1];

  // payload carried down the pipeline after the exponent is known
  typedef struct packed {
    logic             use_direct;
    logic [PIX_W-1:0] direct;
    logic [31:0]      c255;
    logic [4:0]       ip;
    logic [19:0]      u;
    logic [31:0]      p;
  } pipe_t;

  // bit-pair integer square root
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    bitv = 64'd1 << 62;
    rem  = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2 of 1..256 in Q.20 by repeated squaring of the mantissa
  function automatic longint unsigned log2_q20(input int v);
    int n;
    longint unsigned m;
    longint unsigned frac;
    n    = 0;
    frac = 0;
    if (v == 0) return 0;
    while (n < 31 && (v >> (n + 1)) != 0) n++;
    m = longint'(v) << (MANT_BITS - n);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m    = (m * m) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(n) << FRAC_BITS) | frac;
  endfunction

  // log2(255) - log2(x), zero entry unused
  function automatic tab_t build_d_tab();
    tab_t t;
    longint unsigned v;
    for (int x = 0; x < 256; x++) begin
      v    = (x == 0) ? 64'd0 : log2_q20(255) - log2_q20(x);
      t[x] = v[TAB_W-1:0];
    end
    return t;
  endfunction

  // ln(x+1) in Q.20
  function automatic tab_t build_ln_tab();
    tab_t t;
    longint unsigned v;
    for (int x = 0; x < 256; x++) begin
      v    = (log2_q20(x + 1) * LN2_Q30 + (64'd1 << (MANT_BITS - 1))) >> MANT_BITS;
      t[x] = v[TAB_W-1:0];
    end
    return t;
  endfunction

  // roots 2^(2^-i) in Q2.30, entry 0 is 2.0
  function automatic root_t build_roots();
    root_t t;
    longint unsigned r;
    r    = 64'd2 << MANT_BITS;
    t[0] = r[31:0];
    for (int i = 1; i <= EXP_STEPS; i++) begin
      r    = isqrt(r << MANT_BITS);
      t[i] = r[31:0];
    end
    return t;
  endfunction

  localparam tab_t  D_TAB  = build_d_tab();
  localparam tab_t  LN_TAB = build_ln_tab();
  localparam root_t ROOTS  = build_roots();

endpackage

### design/glpt_front.sv
// glpt_front: table lookup, exponent product and log-mode result (3 stages)
// depends on glpt_pkg
`timescale 1ns / 1ps

module glpt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [glpt_pkg::PIX_W-1:0]    pixel,
  input  logic                          mode,
  input  logic [glpt_pkg::C_W-1:0]      scale_c,
  input  logic [glpt_pkg::G_W-1:0]      gamma_exp,
  output logic                          out_valid,
  output glpt_pkg::pipe_t               out_data
);

  // stage a: table lookup
  logic                        va_r;
  logic [glpt_pkg::TAB_W-1:0]  d_r, ln_r;
  logic                        xz_r;

  // stage b: products
  logic                        vb_r;
  logic [glpt_pkg::E_W-1:0]    e_r, e_nxt;
  logic [glpt_pkg::PIX_W-1:0]  ylog_r, ylog_nxt;
  logic [glpt_pkg::PIX_W-1:0]  dir0_r, dir0_nxt;
  logic [31:0]                 c255_r, c255_nxt;
  logic                        xzb_r, gz_r, modeb_r;

  // stage c: split exponent
  logic                        vc_r;
  glpt_pkg::pipe_t             pc_r, pc_nxt;

  logic [42:0] ge_prod;
  logic [42:0] ge_rnd;
  logic [46:0] cl_prod;
  logic [10:0] ylog_full;
  logic [16:0] dir_full;
  logic [6:0]  ip_full;
  logic [19:0] f_val;

  always_comb begin
    c255_nxt  = {scale_c, 8'd0} - {8'd0, scale_c};
    ge_prod   = {3'd0, gamma_exp} * {20'd0, d_r};
    ge_rnd    = (ge_prod + 43'd32768) >> 16;
    e_nxt     = ge_rnd[glpt_pkg::E_W-1:0];
    cl_prod   = {23'd0, scale_c} * {24'd0, ln_r};
    ylog_full = 11'((cl_prod + (47'd1 << 35)) >> 36);
    ylog_nxt  = (ylog_full > 11'd255) ? 8'd255 : ylog_full[7:0];
    dir_full  = 17'(({1'b0, c255_nxt} + 33'd32768) >> 16);
    dir0_nxt  = (dir_full > 17'd255) ? 8'd255 : dir_full[7:0];
  end

  always_comb begin
    ip_full           = e_r[26:20];
    f_val             = e_r[19:0];
    pc_nxt.c255       = c255_r;
    pc_nxt.ip         = ip_full[4:0];
    pc_nxt.u          = 20'(21'h100000 - {1'b0, f_val});
    pc_nxt.p          = (f_val == 20'd0) ? 32'h8000_0000 : 32'h4000_0000;
    pc_nxt.use_direct = modeb_r | xzb_r | (ip_full >= 7'd17);
    if (modeb_r) begin
      pc_nxt.direct = ylog_r;
    end else if (xzb_r && gz_r) begin
      pc_nxt.direct = dir0_r;
    end else begin
      pc_nxt.direct = '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= glpt_pkg::D_TAB[pixel];
      ln_r    <= glpt_pkg::LN_TAB[pixel];
      xz_r    <= (pixel == '0);
      e_r     <= e_nxt;
      ylog_r  <= ylog_nxt;
      dir0_r  <= dir0_nxt;
      c255_r  <= c255_nxt;
      xzb_r   <= xz_r;
      gz_r    <= (gamma_exp == '0);
      modeb_r <= mode;
      pc_r    <= pc_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_data  = pc_r;

endmodule

### design/glpt_exp_step.sv
// glpt_exp_step: one stage of the 2^u product, multiplies by its root when its bit of u is set
// depends on glpt_pkg
`timescale 1ns / 1ps

module glpt_exp_step #(
  parameter int STEP = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  glpt_pkg::pipe_t in_data,
  output logic            out_valid,
  output glpt_pkg::pipe_t out_data
);

  localparam logic [31:0] ROOT = glpt_pkg::ROOTS[STEP];

  logic            v_r;
  glpt_pkg::pipe_t d_r, d_nxt;
  logic [63:0]     prod;

  // rounded Q2.30 product when this bit of u is set
  always_comb begin
    d_nxt = in_data;
    prod  = {32'd0, in_data.p} * {32'd0, ROOT};
    if (in_data.u[glpt_pkg::FRAC_BITS-STEP]) begin
      d_nxt.p = 32'((prod + (64'd1 << 29)) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

### design/glpt_back.sv
// glpt_back: scale by c*255, rounding shift, saturation or direct value, and output register
// depends on glpt_pkg
`timescale 1ns / 1ps

module glpt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  glpt_pkg::pipe_t            in_data,
  output logic                       out_valid,
  output logic [glpt_pkg::PIX_W-1:0] out_pixel
);

  // stage 1: partial products
  logic        v1_r;
  logic [47:0] lo_r, hi_r;
  logic [4:0]  ip_r;
  logic        dir_r;
  logic [7:0]  dval_r;

  // stage 2: output register
  logic        v2_r;
  logic [7:0]  pix_r, pix_nxt;

  logic [63:0] prod, rounded;
  logic [5:0]  sh;

  always_comb begin
    prod    = {hi_r, 16'd0} + {16'd0, lo_r};
    sh      = 6'd47 + {1'b0, ip_r};
    rounded = (prod + (64'd1 << (sh - 6'd1))) >> sh;
    if (dir_r) begin
      pix_nxt = dval_r;
    end else if (rounded > 64'd255) begin
      pix_nxt = 8'd255;
    end else begin
      pix_nxt = rounded[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= {16'd0, in_data.c255} * {32'd0, in_data.p[15:0]};
      hi_r   <= {16'd0, in_data.c255} * {32'd0, in_data.p[31:16]};
      ip_r   <= in_data.ip;
      dir_r  <= in_data.use_direct;
      dval_r <= in_data.direct;
      pix_r  <= pix_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pixel = pix_r;

endmodule

### design/gamma_log_pixel_transform_top.sv
// gamma_log_pixel_transform_top: throughput one pixel per cycle, the
// pipeline advances as a whole whenever the output register is empty or
// being taken
// the 20-stage 2^u root product sets the depth
// synchronous active-low reset clears all valid bits and sets mode 0, c 1.0,
// gamma 1.0
`timescale 1ns / 1ps

module gamma_log_pixel_transform_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] pixel_out
  input  logic                          cfg_we,
  input  logic [glpt_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [glpt_pkg::C_W-1:0]      cfg_wdata
);

  localparam int N = glpt_pkg::EXP_STEPS;

  logic                        mode_r;
  logic [glpt_pkg::C_W-1:0]    scale_r;
  logic [glpt_pkg::G_W-1:0]    gamma_r;
  logic                        en;

  logic                        sv   [N+1];
  glpt_pkg::pipe_t             sd   [N+1];

  // whole pipeline moves unless the output register holds an untaken result
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      scale_r <= 24'd65536;
      gamma_r <= 20'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        glpt_pkg::REG_MODE:  mode_r  <= cfg_wdata[0];
        glpt_pkg::REG_SCALE: scale_r <= cfg_wdata;
        glpt_pkg::REG_GAMMA: gamma_r <= cfg_wdata[glpt_pkg::G_W-1:0];
        default: ;
      endcase
    end
  end

  glpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .pixel     (in_tdata),
    .mode      (mode_r),
    .scale_c   (scale_r),
    .gamma_exp (gamma_r),
    .out_valid (sv[0]),
    .out_data  (sd[0])
  );

  // root product chain
  for (genvar i = 1; i <= N; i++) begin : g_exp
    glpt_exp_step #(.STEP(i)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sv[i-1]),
      .in_data   (sd[i-1]),
      .out_valid (sv[i]),
      .out_data  (sd[i])
    );
  end

  glpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sv[N]),
    .in_data   (sd[N]),
    .out_valid (out_tvalid),
    .out_pixel (out_tdata)
  );

endmodule
